// ===== hw/rtl/qte_pkg.sv =====
package qte_pkg;

    localparam int CORDIC_STAGES = 16;
    localparam int NST = (CORDIC_STAGES > 24) ? 24 : ((CORDIC_STAGES < 1) ? 0 : CORDIC_STAGES);
    localparam int SQ_STEPS = 32;
    localparam int VW = 38;
    localparam int ZW = 30;
    localparam int HALF_PI = 26353589;
    localparam int OUT_LIMIT = 25736;

    typedef logic signed [VW-1:0] t_vec;
    typedef logic signed [ZW-1:0] t_ang;

    function automatic t_ang atan_tab(input int i);
        t_ang v;
        v = '0;
        unique case (i)
            0: v = ZW'(13176795);
            1: v = ZW'(7778716);
            2: v = ZW'(4110060);
            3: v = ZW'(2086331);
            4: v = ZW'(1047214);
            5: v = ZW'(524117);
            6: v = ZW'(262123);
            7: v = ZW'(131069);
            default: v = ZW'(1 << (24 - i));
        endcase
        return v;
    endfunction

endpackage

// ===== hw/rtl/qte_sqrt.sv =====
module qte_sqrt (
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [63:0] i_val,
    output logic [31:0] o_root
);
    import qte_pkg::*;

    logic [63:0] r_rem [SQ_STEPS];
    logic [63:0] r_res [SQ_STEPS];

    for (genvar k = 0; k < SQ_STEPS; k++) begin : g_step
        localparam logic [63:0] BIT = 64'(1) << (62 - 2 * k);
        logic [63:0] w_rem;
        logic [63:0] w_res;
        logic [63:0] w_trial;
        if (k == 0) begin : g_first
            assign w_rem = i_val;
            assign w_res = '0;
        end else begin : g_next
            assign w_rem = r_rem[k-1];
            assign w_res = r_res[k-1];
        end
        assign w_trial = w_res + BIT;
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (w_rem >= w_trial) begin
                    r_rem[k] <= w_rem - w_trial;
                    r_res[k] <= (w_res >> 1) + BIT;
                end else begin
                    r_rem[k] <= w_rem;
                    r_res[k] <= w_res >> 1;
                end
            end
        end
    end

    assign o_root = r_res[SQ_STEPS-1][31:0];
endmodule

// ===== hw/rtl/qte_cordic.sv =====
module qte_cordic (
    input  logic                 i_clk,
    input  logic                 i_en,
    input  qte_pkg::t_vec        i_y,
    input  qte_pkg::t_vec        i_x,
    output qte_pkg::t_ang        o_z
);
    import qte_pkg::*;

    t_vec r_x [NST+1];
    t_vec r_y [NST+1];
    t_ang r_z [NST+1];
    logic r_zero [NST+1];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_zero[0] <= (i_x == '0) && (i_y == '0);
            if (i_x[VW-1]) begin
                if (!i_y[VW-1]) begin
                    r_x[0] <= i_y;
                    r_y[0] <= -i_x;
                    r_z[0] <= ZW'(HALF_PI);
                end else begin
                    r_x[0] <= -i_y;
                    r_y[0] <= i_x;
                    r_z[0] <= -ZW'(HALF_PI);
                end
            end else begin
                r_x[0] <= i_x;
                r_y[0] <= i_y;
                r_z[0] <= '0;
            end
        end
    end

    for (genvar i = 0; i < NST; i++) begin : g_rot
        t_vec w_xs;
        t_vec w_ys;
        assign w_xs = r_x[i] >>> i;
        assign w_ys = r_y[i] >>> i;
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_zero[i+1] <= r_zero[i];
                if (r_y[i] > 0) begin
                    r_x[i+1] <= r_x[i] + w_ys;
                    r_y[i+1] <= r_y[i] - w_xs;
                    r_z[i+1] <= r_z[i] + atan_tab(i);
                end else begin
                    r_x[i+1] <= r_x[i] - w_ys;
                    r_y[i+1] <= r_y[i] + w_xs;
                    r_z[i+1] <= r_z[i] - atan_tab(i);
                end
            end
        end
    end

    assign o_z = r_zero[NST] ? '0 : r_z[NST];
endmodule

// ===== hw/rtl/quaternion_to_euler.sv =====
// Registers in order: products, sums, square-root steps, CORDIC stages, output.
// Throughput: one beat per cycle; the whole pipeline holds while the output beat
// is stalled, input is taken whenever the output register is free or being taken.
// Reset (i_rst_n low, synchronous) clears all valid bits; data registers are not reset.
module quaternion_to_euler (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [63:0] i_s_tdata,  // quat_w, quat_x, quat_y, quat_z
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [47:0] o_m_tdata   // roll_angle, pitch_angle, yaw_angle
);
    import qte_pkg::*;

    localparam int LAT = 2 + SQ_STEPS + 1 + NST + 1;

    logic w_en;
    logic [LAT-1:0] r_vld;

    assign w_en = !o_m_tvalid || i_m_tready;
    assign o_s_tready = w_en;
    assign o_m_tvalid = r_vld[LAT-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[LAT-2:0], i_s_tvalid};
        end
    end

    // products
    logic signed [15:0] w_w, w_x, w_y, w_z;
    assign w_w = i_s_tdata[15:0];
    assign w_x = i_s_tdata[31:16];
    assign w_y = i_s_tdata[47:32];
    assign w_z = i_s_tdata[63:48];

    logic signed [31:0] r_wx, r_yz, r_xx, r_yy, r_wz, r_xy, r_zz, r_wy, r_xz;
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_wx <= w_w * w_x;
            r_yz <= w_y * w_z;
            r_xx <= w_x * w_x;
            r_yy <= w_y * w_y;
            r_wz <= w_w * w_z;
            r_xy <= w_x * w_y;
            r_zz <= w_z * w_z;
            r_wy <= w_w * w_y;
            r_xz <= w_x * w_z;
        end
    end

    // sums
    logic signed [35:0] w_sr, w_cr, w_sy, w_cy, w_a, w_b, w_t2;
    assign w_t2 = 36'(2) * (36'(r_wy) - 36'(r_xz));
    assign w_sr = 36'(2) * (36'(r_wx) + 36'(r_yz));
    assign w_cr = 36'(1 << 28) - 36'(2) * (36'(r_xx) + 36'(r_yy));
    assign w_sy = 36'(2) * (36'(r_wz) + 36'(r_xy));
    assign w_cy = 36'(1 << 28) - 36'(2) * (36'(r_yy) + 36'(r_zz));
    assign w_a = 36'(1 << 28) + w_t2;
    assign w_b = 36'(1 << 28) - w_t2;

    t_vec r_sr, r_cr, r_sy, r_cy;
    logic [33:0] r_a, r_b;
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_sr <= VW'(w_sr);
            r_cr <= VW'(w_cr);
            r_sy <= VW'(w_sy);
            r_cy <= VW'(w_cy);
            r_a  <= w_a[35] ? '0 : w_a[33:0];
            r_b  <= w_b[35] ? '0 : w_b[33:0];
        end
    end

    // square roots, with roll/yaw operands delayed alongside
    logic [31:0] w_sa, w_sb;
    qte_sqrt u_sqrt_a (.i_clk, .i_en(w_en), .i_val(64'({r_a, 28'b0})), .o_root(w_sa));
    qte_sqrt u_sqrt_b (.i_clk, .i_en(w_en), .i_val(64'({r_b, 28'b0})), .o_root(w_sb));

    t_vec r_dsr [SQ_STEPS];
    t_vec r_dcr [SQ_STEPS];
    t_vec r_dsy [SQ_STEPS];
    t_vec r_dcy [SQ_STEPS];
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_dsr[0] <= r_sr;
            r_dcr[0] <= r_cr;
            r_dsy[0] <= r_sy;
            r_dcy[0] <= r_cy;
            for (int k = 1; k < SQ_STEPS; k++) begin
                r_dsr[k] <= r_dsr[k-1];
                r_dcr[k] <= r_dcr[k-1];
                r_dsy[k] <= r_dsy[k-1];
                r_dcy[k] <= r_dcy[k-1];
            end
        end
    end

    t_ang w_zr, w_zp, w_zy;
    qte_cordic u_cordic_roll (
        .i_clk, .i_en(w_en), .i_y(r_dsr[SQ_STEPS-1]), .i_x(r_dcr[SQ_STEPS-1]), .o_z(w_zr)
    );
    qte_cordic u_cordic_pitch (
        .i_clk, .i_en(w_en), .i_y(VW'(w_sa)), .i_x(VW'(w_sb)), .o_z(w_zp)
    );
    qte_cordic u_cordic_yaw (
        .i_clk, .i_en(w_en), .i_y(r_dsy[SQ_STEPS-1]), .i_x(r_dcy[SQ_STEPS-1]), .o_z(w_zy)
    );

    function automatic logic [15:0] angle_out(input logic signed [31:0] q);
        logic signed [31:0] v;
        logic [15:0] o;
        v = (q + 32'sd1024) >>> 11;
        if (v > OUT_LIMIT) o = 16'(OUT_LIMIT);
        else if (v < -OUT_LIMIT) o = 16'(-OUT_LIMIT);
        else o = v[15:0];
        return o;
    endfunction

    logic signed [31:0] w_pq;
    assign w_pq = 32'sd2 * 32'(w_zp) - 32'(HALF_PI);

    logic [47:0] r_out;
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out <= {angle_out(32'(w_zy)), angle_out(w_pq), angle_out(32'(w_zr))};
        end
    end
    assign o_m_tdata = r_out;

`ifndef SYNTH
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready) |=> (o_m_tvalid && $stable(o_m_tdata)))
        else $error("output beat changed under stall");
    a_rst: assert property (@(posedge i_clk) !i_rst_n |=> !o_m_tvalid)
        else $error("valid after reset");
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_s_tready && i_s_tvalid) |=> r_vld[0])
        else $error("accepted beat lost");
`endif
endmodule

// ===== tb/quaternion_to_euler_tb.sv =====
module quaternion_to_euler_tb;
    import qte_pkg::*;

    localparam int HALF_PI_Q24 = 26353589;
    localparam int ANGLE_LIMIT = 25736;
    localparam int MAX_STAGE_TAB = 24;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int N_RANDOM = 1700;

    typedef struct packed {
        logic signed [15:0] yaw;
        logic signed [15:0] pitch;
        logic signed [15:0] roll;
    } euler_t;

    // floor(v / 2^s)
    function automatic longint floor_shift(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint arctan_step(int i);
        longint tab [MAX_STAGE_TAB] = '{13176795, 7778716, 4110060, 2086331, 1047214,
            524117, 262123, 131069, 65536, 32768, 16384, 8192, 4096, 2048, 1024, 512,
            256, 128, 64, 32, 16, 8, 4, 2};
        return tab[i];
    endfunction

    function automatic longint int_sqrt(longint unsigned v);
        longint unsigned rem, res, b;
        rem = v;
        res = 0;
        b = 64'd1 << 62;
        while (b != 0) begin
            if (rem >= res + b) begin
                rem = rem - (res + b);
                res = (res >> 1) + b;
            end else begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return longint'(res);
    endfunction

    function automatic longint vector_angle(longint yi, longint xi);
        longint xv, yv, zv, tmp, xs, ys;
        int n;
        xv = xi;
        yv = yi;
        zv = 0;
        n = (CORDIC_STAGES > MAX_STAGE_TAB) ? MAX_STAGE_TAB : CORDIC_STAGES;
        if (xv == 0 && yv == 0) return 0;
        if (xv < 0) begin
            if (yv >= 0) begin
                tmp = xv; xv = yv; yv = -tmp; zv = HALF_PI_Q24;
            end else begin
                tmp = xv; xv = -yv; yv = tmp; zv = -HALF_PI_Q24;
            end
        end
        for (int i = 0; i < n; i++) begin
            xs = floor_shift(xv, i);
            ys = floor_shift(yv, i);
            if (yv > 0) begin
                xv += ys; yv -= xs; zv += arctan_step(i);
            end else begin
                xv -= ys; yv += xs; zv -= arctan_step(i);
            end
        end
        return zv;
    endfunction

    function automatic logic signed [15:0] to_q13(longint q24);
        longint v;
        v = floor_shift(q24 + 1024, 11);
        if (v > ANGLE_LIMIT) v = ANGLE_LIMIT;
        if (v < -ANGLE_LIMIT) v = -ANGLE_LIMIT;
        return 16'(v);
    endfunction

    function automatic euler_t quat_to_euler(logic [63:0] q);
        longint w, x, y, z, sr, cr, sy, cy, t, a, b, one;
        euler_t e;
        one = 64'sd1 << 28;
        w = longint'($signed(q[15:0]));
        x = longint'($signed(q[31:16]));
        y = longint'($signed(q[47:32]));
        z = longint'($signed(q[63:48]));
        sr = 2 * (w * x + y * z);
        cr = one - 2 * (x * x + y * y);
        sy = 2 * (w * z + x * y);
        cy = one - 2 * (y * y + z * z);
        t = w * y - x * z;
        a = one + 2 * t;
        b = one - 2 * t;
        if (a < 0) a = 0;
        if (b < 0) b = 0;
        e.roll = to_q13(vector_angle(sr, cr));
        e.pitch = to_q13(2 * vector_angle(int_sqrt(a << 28), int_sqrt(b << 28)) - HALF_PI_Q24);
        e.yaw = to_q13(vector_angle(sy, cy));
        return e;
    endfunction

    int n_errors = 0;

    task automatic report(string msg);
        $display("mismatch: %s", msg);
        n_errors++;
    endtask

    class euler_scoreboard;
        euler_t pending[$];

        function void note_quat(logic [63:0] q);
            pending.push_back(quat_to_euler(q));
        endfunction

        task check_angles(logic [47:0] d);
            euler_t got, exp_e;
            got = d;
            if (pending.size() == 0) begin
                report($sformatf("unexpected beat %h", d));
            end else begin
                exp_e = pending.pop_front();
                if (got.roll !== exp_e.roll)
                    report($sformatf("roll %0d exp %0d", got.roll, exp_e.roll));
                if (got.pitch !== exp_e.pitch)
                    report($sformatf("pitch %0d exp %0d", got.pitch, exp_e.pitch));
                if (got.yaw !== exp_e.yaw)
                    report($sformatf("yaw %0d exp %0d", got.yaw, exp_e.yaw));
            end
        endtask
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_s_tvalid = 1'b0;
    logic o_s_tready;
    logic [63:0] i_s_tdata = '0;
    logic o_m_tvalid;
    logic i_m_tready = 1'b0;
    logic [47:0] o_m_tdata;

    euler_scoreboard sb = new();
    int idle_cycles = 0;

    quaternion_to_euler i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_tvalid(i_s_tvalid), .o_s_tready(o_s_tready), .i_s_tdata(i_s_tdata),
        .o_m_tvalid(o_m_tvalid), .i_m_tready(i_m_tready), .o_m_tdata(o_m_tdata)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic int rand_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_s_tvalid && o_s_tready) sb.note_quat(i_s_tdata);
            if (o_m_tvalid && i_m_tready) sb.check_angles(o_m_tdata);
            if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("simulation failed");
                $finish;
            end
        end
    end

    // sink with random stalls; phases with no stall
    initial begin
        int g;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if ($urandom_range(0, 3) == 0) begin
                g = rand_gap();
                if (g > 0) begin
                    i_m_tready <= 1'b0;
                    repeat (g) @(negedge i_clk);
                end
            end
            i_m_tready <= 1'b1;
            repeat ($urandom_range(0, 20)) @(negedge i_clk);
        end
    end

    task automatic send_quat(logic signed [15:0] w, x, y, z, bit allow_gap);
        int g;
        g = allow_gap ? rand_gap() : 0;
        if (g > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (g) @(negedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata <= {z, y, x, w};
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    function automatic logic signed [15:0] rand_comp();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return 16'($urandom);
        if (r == 1) return ($urandom_range(0, 1)) ? 16'sd16384 : -16'sd16384;
        return 16'($signed($urandom_range(0, 32768)) - 16384);
    endfunction

    initial begin
        real a, b, c, d, n;
        logic signed [15:0] cw, cx, cy, cz;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        // directed: identity, axes, gimbal lock, zeros, extremes, raw bit patterns
        send_quat(16384, 0, 0, 0, 0);
        send_quat(-16384, 0, 0, 0, 0);
        send_quat(0, 16384, 0, 0, 0);
        send_quat(0, 0, 16384, 0, 0);
        send_quat(0, 0, 0, 16384, 0);
        send_quat(0, -16384, 0, 0, 0);
        send_quat(0, 0, -16384, 0, 0);
        send_quat(0, 0, 0, -16384, 0);
        send_quat(11585, 0, 11585, 0, 0);
        send_quat(11585, 0, -11585, 0, 0);
        send_quat(8192, 8192, 8192, -8192, 0);
        send_quat(0, 0, 0, 0, 0);
        send_quat(16384, 16384, 16384, 16384, 0);
        send_quat(-16384, -16384, -16384, -16384, 0);
        send_quat(16384, -16384, 16384, -16384, 0);
        send_quat(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 0);
        send_quat(16'h8000, 16'h8000, 16'h8000, 16'h8000, 0);
        send_quat(16'hffff, 16'h0000, 16'hffff, 16'h0000, 0);
        send_quat(16'h5555, 16'haaaa, 16'h5555, 16'haaaa, 0);
        send_quat(16'haaaa, 16'h5555, 16'haaaa, 16'h5555, 0);
        send_quat(0, 16384, 0, 16384, 0);
        i_s_tvalid <= 1'b0;
        while (sb.pending.size() != 0) @(negedge i_clk);
        for (int k = 0; k < N_RANDOM; k++) begin
            if ($urandom_range(0, 3) != 0) begin
                // near-unit quaternion
                a = real'($urandom_range(0, 20000)) - 10000.0;
                b = real'($urandom_range(0, 20000)) - 10000.0;
                c = real'($urandom_range(0, 20000)) - 10000.0;
                d = real'($urandom_range(0, 20000)) - 10000.0;
                n = $sqrt(a * a + b * b + c * c + d * d);
                if (n < 1.0) n = 1.0;
                cw = 16'($rtoi(a * 16384.0 / n));
                cx = 16'($rtoi(b * 16384.0 / n));
                cy = 16'($rtoi(c * 16384.0 / n));
                cz = 16'($rtoi(d * 16384.0 / n));
            end else begin
                cw = rand_comp(); cx = rand_comp(); cy = rand_comp(); cz = rand_comp();
            end
            send_quat(cw, cx, cy, cz, (k % 400) >= 100);
            if (k == N_RANDOM / 2) begin
                i_s_tvalid <= 1'b0;
                while (sb.pending.size() != 0) @(negedge i_clk);
            end
        end
        i_s_tvalid <= 1'b0;
        while (sb.pending.size() != 0) @(negedge i_clk);
        repeat (100) @(negedge i_clk);
        if (n_errors == 0 && sb.pending.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end
endmodule
